// File: sv/srag_pkg.sv
// Shared types and constants for the strided repack address generator.
// No dependencies; used by every module of the block except srag_fifo.
package srag_pkg;

	// configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 13;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_UNPACK_MODE    = 3'd0,
		REG_IMAGE_BATCH    = 3'd1,
		REG_IMAGE_CHANNELS = 3'd2,
		REG_IMAGE_HEIGHT   = 3'd3,
		REG_IMAGE_WIDTH    = 3'd4,
		REG_ROW_STRIDE     = 3'd5,
		REG_COL_STRIDE     = 3'd6
	} cfg_reg_t;

	// register field widths as written
	localparam int BATCH_FIELD_BITS  = 11;
	localparam int DIM_FIELD_BITS    = 13;
	localparam int STRIDE_FIELD_BITS = 5;

	// batch count 1..1024, position 0..1023
	localparam int BATCH_MAX  = 1024;
	localparam int BATCH_BITS = 10;
	localparam int BATCH_W    = 11;

	localparam logic MODE_PACK   = 1'b0;
	localparam logic MODE_UNPACK = 1'b1;

	// per-move classification passed from front to back
	typedef struct packed {
		logic in_image;
		logic last;
	} move_flags_t;

endpackage

// File: sv/srag_cfg.sv
// Configuration register file with range clamping.
// Depends on srag_pkg.
module srag_cfg #(
	parameter int DIM_BITS   = 12,
	parameter int MAX_STRIDE = 16,
	localparam int DW        = DIM_BITS + 1,
	localparam int SW_BITS   = $clog2(MAX_STRIDE + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [srag_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [srag_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output logic                                 unpack_mode,
	output logic [srag_pkg::BATCH_W-1:0]         nb,
	output logic [DW-1:0]                        nc,
	output logic [DW-1:0]                        nh,
	output logic [DW-1:0]                        nw,
	output logic [SW_BITS-1:0]                   sh,
	output logic [SW_BITS-1:0]                   sw
);

	localparam int DIM_MAX = 1 << DIM_BITS;

	logic [srag_pkg::DIM_FIELD_BITS-1:0]    dim_f;
	logic [srag_pkg::STRIDE_FIELD_BITS-1:0] str_f;
	logic [srag_pkg::BATCH_FIELD_BITS-1:0]  bat_f;
	logic [DW-1:0]                          dim_c;
	logic [SW_BITS-1:0]                     str_c;
	logic [srag_pkg::BATCH_W-1:0]           bat_c;

	logic                         unpack_q;
	logic [srag_pkg::BATCH_W-1:0] nb_q;
	logic [DW-1:0]                nc_q, nh_q, nw_q;
	logic [SW_BITS-1:0]           sh_q, sw_q;

	assign dim_f = cfg_data[srag_pkg::DIM_FIELD_BITS-1:0];
	assign str_f = cfg_data[srag_pkg::STRIDE_FIELD_BITS-1:0];
	assign bat_f = cfg_data[srag_pkg::BATCH_FIELD_BITS-1:0];

	// zero counts as one, anything above the bound saturates
	always_comb begin
		if (dim_f == '0) begin
			dim_c = DW'(1);
		end else if (32'(dim_f) > DIM_MAX) begin
			dim_c = DW'(DIM_MAX);
		end else begin
			dim_c = DW'(dim_f);
		end
		if (str_f == '0) begin
			str_c = SW_BITS'(1);
		end else if (32'(str_f) > MAX_STRIDE) begin
			str_c = SW_BITS'(MAX_STRIDE);
		end else begin
			str_c = SW_BITS'(str_f);
		end
		if (bat_f == '0) begin
			bat_c = srag_pkg::BATCH_W'(1);
		end else if (32'(bat_f) > srag_pkg::BATCH_MAX) begin
			bat_c = srag_pkg::BATCH_W'(srag_pkg::BATCH_MAX);
		end else begin
			bat_c = bat_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unpack_q <= srag_pkg::MODE_PACK;
			nb_q     <= srag_pkg::BATCH_W'(1);
			nc_q     <= DW'(1);
			nh_q     <= DW'(1);
			nw_q     <= DW'(1);
			sh_q     <= SW_BITS'(1);
			sw_q     <= SW_BITS'(1);
		end else if (cfg_we) begin
			case (srag_pkg::cfg_reg_t'(cfg_index))
				srag_pkg::REG_UNPACK_MODE:    unpack_q <= cfg_data[0];
				srag_pkg::REG_IMAGE_BATCH:    nb_q     <= bat_c;
				srag_pkg::REG_IMAGE_CHANNELS: nc_q     <= dim_c;
				srag_pkg::REG_IMAGE_HEIGHT:   nh_q     <= dim_c;
				srag_pkg::REG_IMAGE_WIDTH:    nw_q     <= dim_c;
				srag_pkg::REG_ROW_STRIDE:     sh_q     <= str_c;
				srag_pkg::REG_COL_STRIDE:     sw_q     <= str_c;
				default: ;
			endcase
		end
	end

	assign unpack_mode = unpack_q;
	assign nb = nb_q;
	assign nc = nc_q;
	assign nh = nh_q;
	assign nw = nw_q;
	assign sh = sh_q;
	assign sw = sw_q;

endmodule

// File: sv/srag_front.sv
// Front end: takes input transfers, walks the packed-order counters and
// classifies each move (inside image, final move). Depends on srag_pkg.
module srag_front #(
	parameter int ADDR_BITS  = 32,
	parameter int DIM_BITS   = 12,
	parameter int MAX_STRIDE = 16,
	localparam int DW        = DIM_BITS + 1,
	localparam int SW_BITS   = $clog2(MAX_STRIDE + 1),
	localparam int PH_W      = $clog2(MAX_STRIDE)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              restart,
	input  logic [srag_pkg::BATCH_W-1:0]      nb,
	input  logic [DW-1:0]                     nc,
	input  logic [DW-1:0]                     nh,
	input  logic [DW-1:0]                     nw,
	input  logic [SW_BITS-1:0]                sh,
	input  logic [SW_BITS-1:0]                sw,
	input  logic                              q_full,
	output logic                              q_push,
	output logic [srag_pkg::BATCH_BITS-1:0]   mv_batch,
	output logic [DIM_BITS-1:0]               mv_chan,
	output logic [DIM_BITS-1:0]               mv_row,
	output logic [DIM_BITS-1:0]               mv_col,
	output logic [ADDR_BITS-1:0]              mv_pidx,
	output srag_pkg::move_flags_t             mv_flags
);

	localparam int RB_W = DIM_BITS + SW_BITS + 1;

	logic [PH_W-1:0]                 prow_q, pcol_q, prow_c, pcol_c;
	logic [srag_pkg::BATCH_BITS-1:0] batch_q, batch_c;
	logic [DIM_BITS-1:0]             chan_q, grow_q, gcol_q, chan_c, grow_c, gcol_c;
	logic [ADDR_BITS-1:0]            pidx_q, pidx_c;

	logic [RB_W-1:0] row_base, col_base, row_full, col_full;
	logic end_prow, end_pcol, end_batch, end_chan, end_grow, end_gcol;
	logic last, in_image, accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// restart clears the walk before this move
	assign prow_c  = restart ? '0 : prow_q;
	assign pcol_c  = restart ? '0 : pcol_q;
	assign batch_c = restart ? '0 : batch_q;
	assign chan_c  = restart ? '0 : chan_q;
	assign grow_c  = restart ? '0 : grow_q;
	assign gcol_c  = restart ? '0 : gcol_q;
	assign pidx_c  = restart ? '0 : pidx_q;

	assign row_base = RB_W'(grow_c) * RB_W'(sh);
	assign col_base = RB_W'(gcol_c) * RB_W'(sw);
	assign row_full = row_base + RB_W'(prow_c);
	assign col_full = col_base + RB_W'(pcol_c);
	assign in_image = (row_full < RB_W'(nh)) && (col_full < RB_W'(nw));

	// grid counter g is at its end when (g+1)*stride >= dim, i.e. g+1 >= ceil(dim/stride)
	assign end_grow  = (row_base + RB_W'(sh)) >= RB_W'(nh);
	assign end_gcol  = (col_base + RB_W'(sw)) >= RB_W'(nw);
	assign end_prow  = (32'(prow_c) + 32'd1) >= 32'(sh);
	assign end_pcol  = (32'(pcol_c) + 32'd1) >= 32'(sw);
	assign end_batch = (32'(batch_c) + 32'd1) >= 32'(nb);
	assign end_chan  = (32'(chan_c) + 32'd1) >= 32'(nc);
	assign last = end_prow && end_pcol && end_batch && end_chan && end_grow && end_gcol;

	assign q_push   = accept;
	assign mv_batch = batch_c;
	assign mv_chan  = chan_c;
	assign mv_row   = DIM_BITS'(row_full);
	assign mv_col   = DIM_BITS'(col_full);
	assign mv_pidx  = pidx_c;
	assign mv_flags = '{in_image: in_image, last: last};

	// carry chain, grid column fastest; on the final move every counter wraps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prow_q  <= '0;
			pcol_q  <= '0;
			batch_q <= '0;
			chan_q  <= '0;
			grow_q  <= '0;
			gcol_q  <= '0;
			pidx_q  <= '0;
		end else if (accept) begin
			pidx_q <= last ? '0 : pidx_c + 1'b1;
			gcol_q <= end_gcol ? '0 : gcol_c + 1'b1;
			if (end_gcol) begin
				grow_q <= end_grow ? '0 : grow_c + 1'b1;
			end else begin
				grow_q <= grow_c;
			end
			if (end_gcol && end_grow) begin
				chan_q <= end_chan ? '0 : chan_c + 1'b1;
			end else begin
				chan_q <= chan_c;
			end
			if (end_gcol && end_grow && end_chan) begin
				batch_q <= end_batch ? '0 : batch_c + 1'b1;
			end else begin
				batch_q <= batch_c;
			end
			if (end_gcol && end_grow && end_chan && end_batch) begin
				pcol_q <= end_pcol ? '0 : pcol_c + 1'b1;
			end else begin
				pcol_q <= pcol_c;
			end
			if (end_gcol && end_grow && end_chan && end_batch && end_pcol) begin
				prow_q <= end_prow ? '0 : prow_c + 1'b1;
			end else begin
				prow_q <= prow_c;
			end
		end
	end

endmodule

// File: sv/srag_fifo.sv
// Small register queue between the front and back ends.
// No package dependencies.
module srag_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/srag_back.sv
// Back end: three-stage address pipeline ((b*C + c)*H + row)*W + col and
// the result register with mode-dependent field selection. Depends on srag_pkg.
module srag_back #(
	parameter int ADDR_BITS = 32,
	parameter int DIM_BITS  = 12,
	localparam int DW       = DIM_BITS + 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              unpack_mode,
	input  logic [DW-1:0]                     nc,
	input  logic [DW-1:0]                     nh,
	input  logic [DW-1:0]                     nw,
	input  logic                              q_empty,
	output logic                              q_pop,
	input  logic [srag_pkg::BATCH_BITS-1:0]   mv_batch,
	input  logic [DIM_BITS-1:0]               mv_chan,
	input  logic [DIM_BITS-1:0]               mv_row,
	input  logic [DIM_BITS-1:0]               mv_col,
	input  logic [ADDR_BITS-1:0]              mv_pidx,
	input  srag_pkg::move_flags_t             mv_flags,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [31:0]                       read_addr,
	output logic [31:0]                       write_addr,
	output logic                              write_zero,
	output logic                              skip_move,
	output logic                              last_move
);

	logic                  en;
	logic                  v_s1, v_s2, v_s3;
	logic [ADDR_BITS-1:0]  base_s1, base_s2;
	logic [DIM_BITS-1:0]   row_s1, col_s1, col_s2;
	logic [ADDR_BITS-1:0]  pidx_s1, pidx_s2;
	srag_pkg::move_flags_t flags_s1, flags_s2;
	logic [ADDR_BITS-1:0]  img;
	logic [63:0]           img_ext, pidx_ext;
	logic [31:0]           rd_s3, wr_s3;
	logic                  wz_s3, sk_s3, last_s3;

	// whole pipe advances together whenever the result register can move
	assign en    = !v_s3 || out_ready;
	assign q_pop = en && !q_empty;

	assign img      = base_s2 * ADDR_BITS'(nw) + ADDR_BITS'(col_s2);
	assign img_ext  = 64'(img);
	assign pidx_ext = 64'(pidx_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s1  <= ADDR_BITS'(mv_batch) * ADDR_BITS'(nc) + ADDR_BITS'(mv_chan);
			row_s1   <= mv_row;
			col_s1   <= mv_col;
			pidx_s1  <= mv_pidx;
			flags_s1 <= mv_flags;

			base_s2  <= base_s1 * ADDR_BITS'(nh) + ADDR_BITS'(row_s1);
			col_s2   <= col_s1;
			pidx_s2  <= pidx_s1;
			flags_s2 <= flags_s1;

			last_s3 <= flags_s2.last;
			if (unpack_mode == srag_pkg::MODE_UNPACK) begin
				rd_s3 <= flags_s2.in_image ? pidx_ext[31:0] : '0;
				wr_s3 <= flags_s2.in_image ? img_ext[31:0] : '0;
				wz_s3 <= 1'b0;
				sk_s3 <= !flags_s2.in_image;
			end else begin
				rd_s3 <= flags_s2.in_image ? img_ext[31:0] : '0;
				wr_s3 <= pidx_ext[31:0];
				wz_s3 <= !flags_s2.in_image;
				sk_s3 <= 1'b0;
			end
		end
	end

	assign out_valid  = v_s3;
	assign read_addr  = rd_s3;
	assign write_addr = wr_s3;
	assign write_zero = wz_s3;
	assign skip_move  = sk_s3;
	assign last_move  = last_s3;

endmodule

// File: sv/strided_repack_address_generator_unit.sv
// Top level of the strided repack (space to batch) address generator.
// Depends on srag_pkg, srag_cfg, srag_front, srag_fifo, srag_back.

// Each input transfer produces one element move in packed order (phase row,
// phase column, batch, channel, grid row, grid column). The block sustains one
// move per clock unless the output stalls: the front end advances its walk
// counters, and the back end's three-stage multiply pipeline takes a new move
// whenever it advances. A move passes through the four-entry queue and three
// pipeline registers to out_valid; the queue lets input keep flowing while the
// output is stalled. Register writes take effect at once and must be made only
// while no moves are in flight. Clamped register values are held, not raw ones.
module strided_repack_address_generator_unit #(
	parameter int ADDR_BITS  = 32,
	parameter int DIM_BITS   = 12,
	parameter int MAX_STRIDE = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [srag_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [srag_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               restart,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [31:0]                        read_addr,
	output logic [31:0]                        write_addr,
	output logic                               write_zero,
	output logic                               skip_move,
	output logic                               last_move
);

	localparam int DW          = DIM_BITS + 1;
	localparam int SW_BITS     = $clog2(MAX_STRIDE + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int FLAG_W      = $bits(srag_pkg::move_flags_t);
	localparam int ENTRY_W     = srag_pkg::BATCH_BITS + 3 * DIM_BITS + ADDR_BITS + FLAG_W;

	logic                            unpack_mode;
	logic [srag_pkg::BATCH_W-1:0]    nb;
	logic [DW-1:0]                   nc, nh, nw;
	logic [SW_BITS-1:0]              sh, sw;

	logic                            q_full, q_empty, q_push, q_pop;
	logic [ENTRY_W-1:0]              q_wdata, q_rdata;

	logic [srag_pkg::BATCH_BITS-1:0] f_batch, b_batch;
	logic [DIM_BITS-1:0]             f_chan, f_row, f_col, b_chan, b_row, b_col;
	logic [ADDR_BITS-1:0]            f_pidx, b_pidx;
	srag_pkg::move_flags_t           f_flags, b_flags;

	srag_cfg #(
		.DIM_BITS   (DIM_BITS),
		.MAX_STRIDE (MAX_STRIDE)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.unpack_mode (unpack_mode),
		.nb          (nb),
		.nc          (nc),
		.nh          (nh),
		.nw          (nw),
		.sh          (sh),
		.sw          (sw)
	);

	srag_front #(
		.ADDR_BITS  (ADDR_BITS),
		.DIM_BITS   (DIM_BITS),
		.MAX_STRIDE (MAX_STRIDE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.restart  (restart),
		.nb       (nb),
		.nc       (nc),
		.nh       (nh),
		.nw       (nw),
		.sh       (sh),
		.sw       (sw),
		.q_full   (q_full),
		.q_push   (q_push),
		.mv_batch (f_batch),
		.mv_chan  (f_chan),
		.mv_row   (f_row),
		.mv_col   (f_col),
		.mv_pidx  (f_pidx),
		.mv_flags (f_flags)
	);

	assign q_wdata = {f_batch, f_chan, f_row, f_col, f_pidx, f_flags};
	assign {b_batch, b_chan, b_row, b_col, b_pidx, b_flags} = q_rdata;

	srag_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	srag_back #(
		.ADDR_BITS (ADDR_BITS),
		.DIM_BITS  (DIM_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.unpack_mode (unpack_mode),
		.nc          (nc),
		.nh          (nh),
		.nw          (nw),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.mv_batch    (b_batch),
		.mv_chan     (b_chan),
		.mv_row      (b_row),
		.mv_col      (b_col),
		.mv_pidx     (b_pidx),
		.mv_flags    (b_flags),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_addr   (read_addr),
		.write_addr  (write_addr),
		.write_zero  (write_zero),
		.skip_move   (skip_move),
		.last_move   (last_move)
	);

endmodule
